// ----- hdl/swap_page_cache_macros.svh -----
// Assertion macros shared by the swap page cache RTL.
`ifndef SWAP_PAGE_CACHE_MACROS_SVH
`define SWAP_PAGE_CACHE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/spc_pkg.sv -----
// Package with the sizes, types and helper functions of the swap page cache.
package spc_pkg;

  localparam int SWAP_SLOTS   = 128;
  localparam int DISK_BLOCKS  = 1024;
  localparam int OP_W         = 2;
  localparam int ADDR_W       = 10;
  localparam int DATA_W       = 32;
  localparam int SLOT_FIELD_W = 7;
  localparam int BYTE_W       = 8;
  localparam int BYTES        = DATA_W / BYTE_W;
  localparam int SLOT_AW      = $clog2(SWAP_SLOTS);
  localparam int DISK_AW      = $clog2(DISK_BLOCKS);

  localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(SWAP_SLOTS - 1);
  localparam logic [DISK_AW-1:0] DISK_LAST = DISK_AW'(DISK_BLOCKS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_SWAP = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWAP,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] page;
  } slot_ent_t;

  typedef struct packed {
    logic [DATA_W-1:0]       data;
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    flushed;
  } res_t;

  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [DISK_AW-1:0] idx;
    logic [DATA_W-1:0]  wdata;
  } dsk_req_t;

  // True when the block address lies inside the disk store.
  function automatic logic addr_in_disk(input logic [ADDR_W-1:0] a);
    return (ADDR_W+1)'(a) < (ADDR_W+1)'(DISK_BLOCKS);
  endfunction

  // Slot index reduced to the width of the result field.
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_AW-1:0] i);
    logic [SLOT_AW+SLOT_FIELD_W-1:0] w;
    w = (SLOT_AW+SLOT_FIELD_W)'(i);
    return w[SLOT_FIELD_W-1:0];
  endfunction

  // Every non-zero byte of the disk word replaces the same byte of the default.
  function automatic logic [DATA_W-1:0] merge_bytes(input logic [DATA_W-1:0] dflt,
                                                    input logic [DATA_W-1:0] disk);
    logic [DATA_W-1:0] res;
    res = dflt;
    for (int k = 0; k < BYTES; k++) begin
      if (disk[BYTE_W*k +: BYTE_W] != '0) begin
        res[BYTE_W*k +: BYTE_W] = disk[BYTE_W*k +: BYTE_W];
      end
    end
    return res;
  endfunction

endpackage

// ----- hdl/spc_if.sv -----
// Request and result channel interfaces of the swap page cache.
interface spc_in_if;
  import spc_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] req_addr;
  logic [DATA_W-1:0] page_data;

  modport source (output valid, operation, req_addr, page_data, input ready);
  modport sink (input valid, operation, req_addr, page_data, output ready);
endinterface

interface spc_out_if;
  import spc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DATA_W-1:0]       result_data;
  logic                    swap_hit;
  logic [SLOT_FIELD_W-1:0] slot_used;
  logic                    table_flushed;

  modport source (output valid, result_data, swap_hit, slot_used, table_flushed,
                  input ready);
  modport sink (input valid, result_data, swap_hit, slot_used, table_flushed,
                output ready);
endinterface

// ----- hdl/spc_disk.sv -----
// Disk store memory with its clearing sweep after reset.
module spc_disk (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spc_pkg::dsk_req_t         req,
  output logic                      ready,
  output logic [spc_pkg::DATA_W-1:0] rd_data
);
  import spc_pkg::*;

  logic [DATA_W-1:0]  mem [DISK_BLOCKS];
  logic               clr_r, clr_nxt;
  logic [DISK_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [DATA_W-1:0]  rd_data_r;

  always_comb begin
    clr_nxt     = clr_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == DISK_LAST) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr) begin
      mem[req.idx] <= req.wdata;
    end
    if (req.rd) begin
      rd_data_r <= mem[req.idx];
    end
  end

  assign ready   = !clr_r;
  assign rd_data = rd_data_r;

endmodule

// ----- hdl/swap_page_cache.sv -----
// Top level of the swap page cache: request sequencer, swap slot memory and valid bits.
`include "swap_page_cache_macros.svh"

// The swap page cache keeps up to 128 address and page pairs in a slot memory in front of a
// disk store of 1024 words, and handles one request word at a time. A swap-in finds the free
// slot by stepping through the valid bits one slot per cycle, and a read scans the slot memory
// one entry per cycle through its single read port, whose output is registered. After reset
// the disk store is cleared by a sweep over its 1024 words, during which no request word is
// accepted. A finished result waits in an output register, and the next request is accepted
// meanwhile.
module swap_page_cache (
  input logic       clk,
  input logic       rst_n,
  spc_in_if.sink    in_ch,
  spc_out_if.source out_ch
);
  import spc_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  logic [SLOT_AW-1:0] idx_r, idx_nxt;
  logic [SLOT_AW-1:0] chk_idx_r, chk_idx_nxt;
  logic              chk_r, chk_nxt;
  logic [SWAP_SLOTS-1:0] valid_r, valid_nxt;
  slot_ent_t         slot_mem [SWAP_SLOTS];
  slot_ent_t         slot_q_r;
  logic              slot_we;
  logic [SLOT_AW-1:0] slot_widx;
  logic              flush;
  res_t              res_r, res_nxt;
  res_t              out_res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic              in_acc;
  logic              hit;
  logic              scan_end;
  dsk_req_t          dsk_req;
  logic              dsk_ready;
  logic [DATA_W-1:0] dsk_q;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign hit      = chk_r && valid_r[chk_idx_r] && (slot_q_r.addr == addr_r);
  assign scan_end = chk_r && (chk_idx_r == SLOT_LAST);

  always_comb begin
    dsk_req.wr    = in_acc && (in_ch.operation == OP_LOAD) && addr_in_disk(in_ch.req_addr);
    dsk_req.rd    = in_acc;
    dsk_req.idx   = in_ch.req_addr[DISK_AW-1:0];
    dsk_req.wdata = in_ch.page_data;
  end

  spc_disk u_disk (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dsk_req),
    .ready   (dsk_ready),
    .rd_data (dsk_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (dsk_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.operation)
            OP_SWAP: state_nxt = S_SWAP;
            OP_READ: state_nxt = S_READ;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SWAP: begin
        if (!valid_r[idx_r] || (idx_r == SLOT_LAST)) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        if (hit || scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    idx_nxt     = idx_r;
    chk_nxt     = chk_r;
    chk_idx_nxt = chk_idx_r;
    res_nxt     = res_r;
    slot_we     = 1'b0;
    slot_widx   = idx_r;
    flush       = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      S_CLEAR: ;
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          chk_nxt = 1'b0;
          res_nxt = '0;
        end
      end
      S_SWAP: begin
        if (!valid_r[idx_r]) begin
          slot_we      = 1'b1;
          res_nxt.slot = slot_field(idx_r);
        end else if (idx_r == SLOT_LAST) begin
          // The table is full: drop every slot and start over at slot 0.
          slot_we         = 1'b1;
          flush           = 1'b1;
          slot_widx       = '0;
          res_nxt.slot    = '0;
          res_nxt.flushed = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_READ: begin
        if (hit) begin
          res_nxt.data = slot_q_r.page;
          res_nxt.hit  = 1'b1;
          res_nxt.slot = slot_field(chk_idx_r);
        end else if (scan_end) begin
          res_nxt.data = merge_bytes(data_r, addr_in_disk(addr_r) ? dsk_q : '0);
        end else begin
          chk_nxt     = 1'b1;
          chk_idx_nxt = idx_r;
          if (idx_r != SLOT_LAST) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (flush) begin
      valid_nxt = '0;
    end
    if (slot_we) begin
      valid_nxt[slot_widx] = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      valid_r     <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r <= in_ch.req_addr;
      data_r <= in_ch.page_data;
    end
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    res_r     <= res_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_widx] <= '{addr: addr_r, page: data_r};
    end
    slot_q_r <= slot_mem[idx_r];
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_data   = out_res_r.data;
  assign out_ch.swap_hit      = out_res_r.hit;
  assign out_ch.slot_used     = out_res_r.slot;
  assign out_ch.table_flushed = out_res_r.flushed;

  `SPC_ASSERT_NEXT(a_swap_sets_valid, slot_we, valid_r != '0, "Swap-in left no valid slot.")
  `SPC_ASSERT_SAME(a_ready_after_clear, in_ch.ready, dsk_ready, "Request taken while disk clears.")
  `SPC_ASSERT_SAME(a_hit_not_flushed, out_ch.valid && out_ch.swap_hit, !out_ch.table_flushed,
                   "Result marks both a hit and a flush.")

endmodule
